FILE: rtl/core/irac_pkg.sv
// Shared types, constants and encode functions for the IR AC frame encoder.
package irac_pkg;

  // Frame words
  localparam logic [23:0] WORD_OFF     = 24'hB27BE0;
  localparam logic [23:0] WORD_DEFAULT = 24'hB21FC8;
  localparam logic [4:0]  SENSOR_IGN   = 5'h1F;

  // Temperature clamp limits
  localparam logic [7:0] TEMP_MIN = 8'd17;
  localparam logic [7:0] TEMP_MAX = 8'd30;

  // Frame layout: header, 48 data pairs, footer
  localparam int PAIRS      = 50;
  localparam int DATA_BITS  = 48;
  localparam int CNT_W      = $clog2(PAIRS);
  localparam logic [CNT_W-1:0] CNT_HEADER = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_FOOTER = CNT_W'(PAIRS - 1);

  // Default depth of the word queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Mode selector codes
  localparam logic [2:0] MODE_COOL = 3'd0;
  localparam logic [2:0] MODE_DRY  = 3'd1;
  localparam logic [2:0] MODE_HEAT = 3'd3;
  localparam logic [2:0] MODE_FAN  = 3'd4;

  // Fan selector codes
  localparam logic [2:0] FAN_LOW  = 3'd1;
  localparam logic [2:0] FAN_MED  = 3'd2;
  localparam logic [2:0] FAN_HIGH = 3'd3;

  // Mode field codes in the word
  localparam logic [1:0] MCODE_COOL = 2'd0;
  localparam logic [1:0] MCODE_DRY  = 2'd1;
  localparam logic [1:0] MCODE_AUTO = 2'd2;
  localparam logic [1:0] MCODE_HEAT = 2'd3;

  // Fan field codes in the word
  localparam logic [2:0] FCODE_AUTO = 3'b101;
  localparam logic [2:0] FCODE_LOW  = 3'b100;
  localparam logic [2:0] FCODE_MED  = 3'b010;
  localparam logic [2:0] FCODE_HIGH = 3'b001;
  localparam logic [2:0] FCODE_FAN  = 3'b110;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_SPACE = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_HDR_MARK   = 16'd4692;
  localparam logic [15:0] RST_HDR_SPACE  = 16'd4416;
  localparam logic [15:0] RST_BIT_MARK   = 16'd552;
  localparam logic [15:0] RST_ONE_SPACE  = 16'd1656;
  localparam logic [15:0] RST_ZERO_SPACE = 16'd552;
  localparam logic [15:0] RST_GAP_SPACE  = 16'd5244;

  // Timing set handed to the back end
  typedef struct packed {
    logic [15:0] hdr_mark;
    logic [15:0] hdr_space;
    logic [15:0] bit_mark;
    logic [15:0] one_space;
    logic [15:0] zero_space;
    logic [15:0] gap_space;
  } irac_timing_t;

  // Gray-like temperature code, index is clamped temp minus 17
  function automatic logic [3:0] temp_code(input logic [3:0] idx);
    logic [3:0] c;
    case (idx)
      4'd0:    c = 4'h0;
      4'd1:    c = 4'h1;
      4'd2:    c = 4'h3;
      4'd3:    c = 4'h2;
      4'd4:    c = 4'h6;
      4'd5:    c = 4'h7;
      4'd6:    c = 4'h5;
      4'd7:    c = 4'h4;
      4'd8:    c = 4'hC;
      4'd9:    c = 4'hD;
      4'd10:   c = 4'h9;
      4'd11:   c = 4'h8;
      4'd12:   c = 4'hA;
      4'd13:   c = 4'hB;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  // Bit stream of a word: each byte MSB first followed by its inverse
  function automatic logic [DATA_BITS-1:0] expand_word(input logic [23:0] w);
    return {w[23:16], ~w[23:16], w[15:8], ~w[15:8], w[7:0], ~w[7:0]};
  endfunction

endpackage

FILE: rtl/core/ir_ac_frame_encoder.sv
// Top level of the IR AC frame encoder: config registers, front, queue, back.
//
// Each accepted setting (start high while busy is low) yields one frame of 50
// mark/space pairs, one pair per clock on out_valid, with out_last on the
// footer pair. The receiver cannot stall: every out_valid cycle must be taken.
// The back-end pair sequencer sets the pace, with frames following each other
// without gaps. An accepted item passes the queue and the sequencer state
// before its first pair is registered on the outputs. A queue of QUEUE_DEPTH
// words holds settings waiting for the sequencer; busy is high while it is
// full. Timing registers are written through cfg_we/cfg_idx/cfg_wdata and
// should change only while no frame is pending or in flight.
module ir_ac_frame_encoder #(
  parameter int QUEUE_DEPTH = irac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_power_on,
  input  logic [7:0]                     in_temp_c,
  input  logic [2:0]                     in_mode_sel,
  input  logic [2:0]                     in_fan_sel,
  output logic                           out_valid,
  output logic [15:0]                    out_mark_us,
  output logic [15:0]                    out_space_us,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [irac_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                    cfg_wdata
);

  irac_pkg::irac_timing_t timing_r;
  logic [23:0] front_word;
  logic [23:0] q_word;
  logic        q_empty;
  logic        q_full;
  logic        q_pop;
  logic        accept;

  assign busy   = q_full;
  assign accept = start && !q_full;

  // Timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.hdr_mark   <= irac_pkg::RST_HDR_MARK;
      timing_r.hdr_space  <= irac_pkg::RST_HDR_SPACE;
      timing_r.bit_mark   <= irac_pkg::RST_BIT_MARK;
      timing_r.one_space  <= irac_pkg::RST_ONE_SPACE;
      timing_r.zero_space <= irac_pkg::RST_ZERO_SPACE;
      timing_r.gap_space  <= irac_pkg::RST_GAP_SPACE;
    end else if (cfg_we) begin
      case (cfg_idx)
        irac_pkg::REG_HDR_MARK:   timing_r.hdr_mark   <= cfg_wdata;
        irac_pkg::REG_HDR_SPACE:  timing_r.hdr_space  <= cfg_wdata;
        irac_pkg::REG_BIT_MARK:   timing_r.bit_mark   <= cfg_wdata;
        irac_pkg::REG_ONE_SPACE:  timing_r.one_space  <= cfg_wdata;
        irac_pkg::REG_ZERO_SPACE: timing_r.zero_space <= cfg_wdata;
        irac_pkg::REG_GAP_SPACE:  timing_r.gap_space  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  irac_front u_front (
    .power_on (in_power_on),
    .temp_c   (in_temp_c),
    .mode_sel (in_mode_sel),
    .fan_sel  (in_fan_sel),
    .word     (front_word)
  );

  irac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_word (front_word),
    .pop       (q_pop),
    .head_word (q_word),
    .empty     (q_empty),
    .full      (q_full)
  );

  irac_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .timing       (timing_r),
    .q_empty      (q_empty),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_mark_us  (out_mark_us),
    .out_space_us (out_space_us),
    .out_last     (out_last)
  );

endmodule

FILE: rtl/core/irac_front.sv
// Front end: classifies one setting and builds its 24-bit state word.
module irac_front (
  input  logic        power_on,
  input  logic [7:0]  temp_c,
  input  logic [2:0]  mode_sel,
  input  logic [2:0]  fan_sel,
  output logic [23:0] word
);

  logic [7:0] t_clamp;
  logic [7:0] t_idx;
  logic [1:0] mcode;
  logic [2:0] fcode;
  logic [3:0] tcode;

  // Clamp temperature and look up its code
  always_comb begin
    if (temp_c < irac_pkg::TEMP_MIN) begin
      t_clamp = irac_pkg::TEMP_MIN;
    end else if (temp_c > irac_pkg::TEMP_MAX) begin
      t_clamp = irac_pkg::TEMP_MAX;
    end else begin
      t_clamp = temp_c;
    end
    t_idx = t_clamp - irac_pkg::TEMP_MIN;
    tcode = irac_pkg::temp_code(t_idx[3:0]);
  end

  // Mode and fan fields; fan mode overrides the fan field
  always_comb begin
    case (fan_sel)
      irac_pkg::FAN_LOW:  fcode = irac_pkg::FCODE_LOW;
      irac_pkg::FAN_MED:  fcode = irac_pkg::FCODE_MED;
      irac_pkg::FAN_HIGH: fcode = irac_pkg::FCODE_HIGH;
      default:            fcode = irac_pkg::FCODE_AUTO;
    endcase
    case (mode_sel)
      irac_pkg::MODE_COOL: mcode = irac_pkg::MCODE_COOL;
      irac_pkg::MODE_DRY:  mcode = irac_pkg::MCODE_DRY;
      irac_pkg::MODE_HEAT: mcode = irac_pkg::MCODE_HEAT;
      irac_pkg::MODE_FAN: begin
        mcode = irac_pkg::MCODE_COOL;
        fcode = irac_pkg::FCODE_FAN;
      end
      default:             mcode = irac_pkg::MCODE_AUTO;
    endcase
  end

  // Assemble the word
  always_comb begin
    if (!power_on) begin
      word = irac_pkg::WORD_OFF;
    end else begin
      word = {irac_pkg::WORD_DEFAULT[23:16], fcode, irac_pkg::SENSOR_IGN,
              tcode, mcode, irac_pkg::WORD_DEFAULT[1:0]};
    end
  end

endmodule

FILE: rtl/core/irac_queue.sv
// Small word queue between the front and back ends.
module irac_queue #(
  parameter int DEPTH = irac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [23:0] push_word,
  input  logic        pop,
  output logic [23:0] head_word,
  output logic        empty,
  output logic        full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [23:0]      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == CNT_FULL);
  assign head_word = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

FILE: rtl/core/irac_back.sv
// Back end: walks one word through the 50 mark/space pairs of a frame.
module irac_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  irac_pkg::irac_timing_t timing,
  input  logic                   q_empty,
  input  logic [23:0]            q_word,
  output logic                   q_pop,
  output logic                   out_valid,
  output logic [15:0]            out_mark_us,
  output logic [15:0]            out_space_us,
  output logic                   out_last
);

  logic                          active_r, active_nxt;
  logic [irac_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [irac_pkg::DATA_BITS-1:0] bits_r, bits_nxt;
  logic                          vld_r;
  logic [15:0]                   mark_r, mark_nxt;
  logic [15:0]                   space_r, space_nxt;
  logic                          last_r;
  logic                          at_footer;

  assign at_footer = (cnt_r == irac_pkg::CNT_FOOTER);
  // Next word is taken while the footer pair is being selected, so frames run back to back
  assign q_pop     = (!active_r || at_footer) && !q_empty;

  // Sequencer
  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    bits_nxt   = bits_r;
    if (active_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r != irac_pkg::CNT_HEADER) begin
        bits_nxt = {bits_r[irac_pkg::DATA_BITS-2:0], 1'b0};
      end
      if (at_footer) begin
        active_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      active_nxt = 1'b1;
      cnt_nxt    = irac_pkg::CNT_HEADER;
      bits_nxt   = irac_pkg::expand_word(q_word);
    end
  end

  // Pair selection for the current step
  always_comb begin
    if (cnt_r == irac_pkg::CNT_HEADER) begin
      mark_nxt  = timing.hdr_mark;
      space_nxt = timing.hdr_space;
    end else if (at_footer) begin
      mark_nxt  = timing.bit_mark;
      space_nxt = timing.gap_space;
    end else begin
      mark_nxt  = timing.bit_mark;
      space_nxt = bits_r[irac_pkg::DATA_BITS-1] ? timing.one_space : timing.zero_space;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
      vld_r    <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
      vld_r    <= active_r;
      last_r   <= active_r && at_footer;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bits_r  <= bits_nxt;
    mark_r  <= mark_nxt;
    space_r <= space_nxt;
  end

  assign out_valid    = vld_r;
  assign out_mark_us  = mark_r;
  assign out_space_us = space_r;
  assign out_last     = last_r;

endmodule
